// ===== rtl/mec_pkg.sv =====
// Shared types, constants and helpers for the four-lane escape-time counter.
// No dependencies; every other file uses this package by scoped name.
package mec_pkg;

  localparam int LANES      = 4;
  localparam int COORD_W    = 32;
  localparam int FRAC_BITS  = 28;
  localparam int CNT_W      = 8;
  localparam int LIM_W      = 4;
  localparam int PROD_W     = 2 * COORD_W;
  localparam int MAG_W      = PROD_W + 1;
  localparam int SUM_W      = PROD_W + 2;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_ADDR_W-1:0] REG_ITER_BUDGET  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ESCAPE_LIMIT = 1'd1;

  localparam logic [CNT_W-1:0] ITER_BUDGET_RST  = 8'd60;
  localparam logic [LIM_W-1:0] ESCAPE_LIMIT_RST = 4'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic mul_en;
    logic upd_en;
  } lane_ctl_t;

  typedef struct packed {
    logic             act;
    logic [CNT_W-1:0] cnt;
  } lane_stat_t;

  typedef struct packed {
    logic load;
  } merge_ctl_t;

  typedef struct packed {
    logic any_act;
    logic can_load;
  } merge_stat_t;

  // Clamp a wide signed sum to the coordinate range.
  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [COORD_W-1:0] res;
    if (!v[SUM_W-1] && (|v[SUM_W-2:COORD_W-1])) begin
      res = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (v[SUM_W-1] && !(&v[SUM_W-2:COORD_W-1])) begin
      res = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res = v[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/mec_if.sv =====
// Valid/ready channel interfaces for the point input and the count result.
// Depends on mec_pkg for field widths.
interface mec_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [mec_pkg::COORD_W-1:0] c_re_0;
  logic signed [mec_pkg::COORD_W-1:0] c_im_0;
  logic signed [mec_pkg::COORD_W-1:0] c_re_1;
  logic signed [mec_pkg::COORD_W-1:0] c_im_1;
  logic signed [mec_pkg::COORD_W-1:0] c_re_2;
  logic signed [mec_pkg::COORD_W-1:0] c_im_2;
  logic signed [mec_pkg::COORD_W-1:0] c_re_3;
  logic signed [mec_pkg::COORD_W-1:0] c_im_3;

  modport source (
    output valid, c_re_0, c_im_0, c_re_1, c_im_1, c_re_2, c_im_2, c_re_3, c_im_3,
    input  ready
  );
  modport sink (
    input  valid, c_re_0, c_im_0, c_re_1, c_im_1, c_re_2, c_im_2, c_re_3, c_im_3,
    output ready
  );
endinterface

interface mec_out_if;
  logic                       valid;
  logic                       ready;
  logic [mec_pkg::CNT_W-1:0]  count_0;
  logic [mec_pkg::CNT_W-1:0]  count_1;
  logic [mec_pkg::CNT_W-1:0]  count_2;
  logic [mec_pkg::CNT_W-1:0]  count_3;

  modport source (
    output valid, count_0, count_1, count_2, count_3,
    input  ready
  );
  modport sink (
    input  valid, count_0, count_1, count_2, count_3,
    output ready
  );
endinterface

// ===== rtl/mandelbrot_escape_count_4lane.sv =====
// Four-lane escape-time counter: top level with sequencer and config registers.
// Depends on mec_pkg, mec_if, mec_lane and mec_merge.
//
// Usage: a transaction on in_chan carries four points c (signed Q4.28). Each
// lane runs z = z*z + c from zero and counts iterations while |z|^2 stays at or
// below escape_limit; the run ends when every lane has escaped or the iteration
// budget is used up. One transaction on out_chan then returns the four counts.
// cfg_we/cfg_addr/cfg_wdata write the iteration budget (index 0) and
// escape_limit (index 1). Write them only while the block is idle.
// Each iteration step is a multiply state followed by a compare/update state.
// One point set is in flight at a time; in_chan.ready rises with the result,
// so a new set is taken only once the last one's result is loaded. The
// result sits in an output register, so a new set is accepted while it
// waits; if the receiver still stalls when the next set finishes, the block
// holds that set and stops accepting until the register frees up. Reset
// (rst_n low, synchronous) restores a budget of 60 and escape_limit = 10
// and empties the pipeline.
module mandelbrot_escape_count_4lane (
  input  logic                               clk,
  input  logic                               rst_n,
  mec_in_if.sink                             in_chan,
  mec_out_if.source                          out_chan,
  input  logic                               cfg_we,
  input  logic [mec_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [mec_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  mec_pkg::state_t                        state_r, state_nxt;
  logic [mec_pkg::CNT_W-1:0]              iter_r, iter_nxt;
  logic [mec_pkg::CNT_W-1:0]              iter_budget_r;
  logic [mec_pkg::LIM_W-1:0]              escape_limit_r;

  mec_pkg::lane_ctl_t                     lane_ctl;
  mec_pkg::lane_stat_t [mec_pkg::LANES-1:0] lane_stat;
  mec_pkg::merge_ctl_t                    merge_ctl;
  mec_pkg::merge_stat_t                   merge_stat;

  logic signed [mec_pkg::COORD_W-1:0]     c_re_a [mec_pkg::LANES];
  logic signed [mec_pkg::COORD_W-1:0]     c_im_a [mec_pkg::LANES];
  logic                                   in_xfer;

  assign c_re_a[0] = in_chan.c_re_0;
  assign c_im_a[0] = in_chan.c_im_0;
  assign c_re_a[1] = in_chan.c_re_1;
  assign c_im_a[1] = in_chan.c_im_1;
  assign c_re_a[2] = in_chan.c_re_2;
  assign c_im_a[2] = in_chan.c_im_2;
  assign c_re_a[3] = in_chan.c_re_3;
  assign c_im_a[3] = in_chan.c_im_3;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_budget_r  <= mec_pkg::ITER_BUDGET_RST;
      escape_limit_r <= mec_pkg::ESCAPE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        mec_pkg::REG_ITER_BUDGET:  iter_budget_r  <= cfg_wdata[mec_pkg::CNT_W-1:0];
        mec_pkg::REG_ESCAPE_LIMIT: escape_limit_r <= cfg_wdata[mec_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mec_pkg::ST_IDLE: begin
        if (in_chan.valid) state_nxt = mec_pkg::ST_MUL;
      end
      mec_pkg::ST_MUL: begin
        if (iter_r == iter_budget_r || !merge_stat.any_act) begin
          state_nxt = mec_pkg::ST_DONE;
        end else begin
          state_nxt = mec_pkg::ST_UPD;
        end
      end
      mec_pkg::ST_UPD: begin
        state_nxt = mec_pkg::ST_MUL;
      end
      mec_pkg::ST_DONE: begin
        if (merge_stat.can_load) state_nxt = mec_pkg::ST_IDLE;
      end
      default: state_nxt = mec_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_chan.ready   = 1'b0;
    lane_ctl        = '0;
    merge_ctl       = '0;
    case (state_r)
      mec_pkg::ST_IDLE: in_chan.ready = 1'b1;
      mec_pkg::ST_MUL:  lane_ctl.mul_en = 1'b1;
      mec_pkg::ST_UPD:  lane_ctl.upd_en = 1'b1;
      mec_pkg::ST_DONE: merge_ctl.load = merge_stat.can_load;
      default: ;
    endcase
    lane_ctl.start = in_xfer;
  end

  assign in_xfer = in_chan.valid && (state_r == mec_pkg::ST_IDLE);

  always_comb begin
    iter_nxt = iter_r;
    if (in_xfer) begin
      iter_nxt = '0;
    end else if (state_r == mec_pkg::ST_UPD) begin
      iter_nxt = iter_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mec_pkg::ST_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  for (genvar k = 0; k < mec_pkg::LANES; k++) begin : g_lane
    mec_lane u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .escape_limit (escape_limit_r),
      .ctl          (lane_ctl),
      .c_re         (c_re_a[k]),
      .c_im         (c_im_a[k]),
      .stat         (lane_stat[k])
    );
  end

  mec_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .stat     (lane_stat),
    .ctl      (merge_ctl),
    .mstat    (merge_stat),
    .out_chan (out_chan)
  );

endmodule

// ===== rtl/mec_lane.sv =====
// One iteration lane: z = z*z + c with escape test, a multiply step then an update step per iteration.
// Depends on mec_pkg.
module mec_lane (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [mec_pkg::LIM_W-1:0]          escape_limit,
  input  mec_pkg::lane_ctl_t                 ctl,
  input  logic signed [mec_pkg::COORD_W-1:0] c_re,
  input  logic signed [mec_pkg::COORD_W-1:0] c_im,
  output mec_pkg::lane_stat_t                stat
);

  logic signed [mec_pkg::COORD_W-1:0] c_re_r, c_im_r, zr_r, zi_r;
  logic signed [mec_pkg::PROD_W-1:0]  r2_r, i2_r, xp_r;
  logic [mec_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                               act_r, act_nxt;
  logic signed [mec_pkg::COORD_W-1:0] zr_nxt, zi_nxt;

  logic [mec_pkg::MAG_W-1:0]          mag, lim;
  logic signed [mec_pkg::PROD_W:0]    diff;
  logic signed [mec_pkg::SUM_W-1:0]   nr_w, ni_w;

  assign mag  = {1'b0, r2_r} + {1'b0, i2_r};
  assign lim  = mec_pkg::MAG_W'(escape_limit) << (2 * mec_pkg::FRAC_BITS);
  assign diff = $signed({r2_r[mec_pkg::PROD_W-1], r2_r})
              - $signed({i2_r[mec_pkg::PROD_W-1], i2_r});
  assign nr_w = mec_pkg::SUM_W'(diff >>> mec_pkg::FRAC_BITS)
              + mec_pkg::SUM_W'(c_re_r);
  assign ni_w = mec_pkg::SUM_W'(xp_r >>> (mec_pkg::FRAC_BITS - 1))
              + mec_pkg::SUM_W'(c_im_r);

  always_comb begin
    cnt_nxt = cnt_r;
    act_nxt = act_r;
    zr_nxt  = zr_r;
    zi_nxt  = zi_r;
    if (ctl.start) begin
      cnt_nxt = '0;
      act_nxt = 1'b1;
      zr_nxt  = '0;
      zi_nxt  = '0;
    end else if (ctl.upd_en && act_r) begin
      if (mag > lim) begin
        act_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        zr_nxt  = mec_pkg::sat_coord(nr_w);
        zi_nxt  = mec_pkg::sat_coord(ni_w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      act_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      act_r <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    zr_r <= zr_nxt;
    zi_r <= zi_nxt;
    if (ctl.start) begin
      c_re_r <= c_re;
      c_im_r <= c_im;
    end
    if (ctl.mul_en) begin
      r2_r <= zr_r * zr_r;
      i2_r <= zi_r * zi_r;
      xp_r <= zr_r * zi_r;
    end
  end

  assign stat.act = act_r;
  assign stat.cnt = cnt_r;

endmodule

// ===== rtl/mec_merge.sv =====
// Merge stage: combines lane activity and holds the result register.
// Depends on mec_pkg and mec_out_if.
module mec_merge (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mec_pkg::lane_stat_t [mec_pkg::LANES-1:0] stat,
  input  mec_pkg::merge_ctl_t                   ctl,
  output mec_pkg::merge_stat_t                  mstat,
  mec_out_if.source                             out_chan
);

  logic [mec_pkg::CNT_W-1:0] cnt_r [mec_pkg::LANES];
  logic                      out_valid_r, out_valid_nxt;
  logic                      any_act;

  always_comb begin
    any_act = 1'b0;
    for (int k = 0; k < mec_pkg::LANES; k++) begin
      any_act = any_act | stat[k].act;
    end
  end

  assign mstat.any_act  = any_act;
  assign mstat.can_load = !out_valid_r || out_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int k = 0; k < mec_pkg::LANES; k++) begin
        cnt_r[k] <= stat[k].cnt;
      end
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.count_0 = cnt_r[0];
  assign out_chan.count_1 = cnt_r[1];
  assign out_chan.count_2 = cnt_r[2];
  assign out_chan.count_3 = cnt_r[3];

endmodule
